/* sv/hbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg
// shared types and constants of the huffman tree bit decoder
// ----------------------------------------------------------------------------
package hbd_pkg;

  // node symbol that marks an internal node
  localparam logic [7:0] INTERNAL_MARK = 8'h30;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // register select, taken from paddr bit 2
  localparam logic REG_ROOT  = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  // one result transaction, last_of_byte is added by the output stage
  typedef struct packed {
    logic [7:0] symbol;
    logic       sym_valid;
    logic       eos;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } stage_ctl_t;

  typedef struct packed {
    logic can_push;
    logic can_flush;
  } stage_sts_t;

endpackage

/* sv/hbd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_out_stage
// holds the newest result until the next one or the end of the byte shows
// whether it is the last of its byte, then moves it into the output register
// ----------------------------------------------------------------------------
module hbd_out_stage
  import hbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  result_t    res,
  output stage_sts_t sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_symbol_valid,
  output logic       out_end_of_stream,
  output logic       out_last_of_byte
);

  logic    pend_v_r, pend_v_nxt;
  result_t pend_r, pend_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;
  logic    out_last_r, out_last_nxt;
  logic    out_free;

  assign out_free      = !out_v_r || !out_stall;
  assign sts.can_push  = !pend_v_r || out_free;
  assign sts.can_flush = !pend_v_r || out_free;

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (ctl.push && (!pend_v_r || out_free)) begin
      // older pending result was not the last of its byte
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt   = res;
      pend_v_nxt = 1'b1;
    end else if (ctl.flush && pend_v_r && out_free) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_v_r;
  assign out_symbol        = out_r.symbol;
  assign out_symbol_valid  = out_r.sym_valid;
  assign out_end_of_stream = out_r.eos;
  assign out_last_of_byte  = out_last_r;

endmodule

/* sv/huffman_tree_bit_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// walks a huffman code tree held in an on-chip node table, one code bit
// per step, and emits decoded symbols with end of stream and end of byte marks
// ----------------------------------------------------------------------------
// node write transaction: taken while idle, and the input stays ready
// byte transaction: the root and current node entries are loaded, then one
//   code bit is walked per step, plus a step to start the walk when the
//   byte begins at an internal node and a step to close the byte; the input
//   stalls until the byte closes, and only then is the next byte taken;
//   the dependent node table read per bit limits the walk
// a result enters the output register in the cycle after the next result of
//   the byte is pushed or the byte closes; output stall holds the walk
// synchronous active-low reset clears walk state, bit count and registers;
//   the node table is not cleared and must be written before use
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder
  import hbd_pkg::*;
#(
  parameter int NODE_COUNT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [8:0]  in_node_index,
  input  logic [7:0]  in_node_symbol,
  input  logic [8:0]  in_left_child,
  input  logic [8:0]  in_right_child,
  input  logic [7:0]  in_compressed_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic        out_symbol_valid,
  output logic        out_end_of_stream,
  output logic        out_last_of_byte,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(NODE_COUNT);   // table index width
  localparam int EW = 8 + 2 * AW;           // entry: symbol, left, right
  localparam int RW = 10;                   // remainder width for 9-bit indexes

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LROOT = 3'd1;   // root entry arriving
  localparam logic [2:0] S_LCUR  = 3'd2;   // current node entry arriving
  localparam logic [2:0] S_BIT   = 3'd3;   // bit at a known node entry
  localparam logic [2:0] S_CHILD = 3'd4;   // child entry arriving
  localparam logic [2:0] S_FLUSH = 3'd5;   // close the byte

  // reduce an index modulo the table depth with a short compare-subtract chain
  function automatic logic [AW-1:0] wrap_idx(input logic [8:0] v);
    logic [RW-1:0] r;
    r = {1'b0, v};
    for (int k = 8; k >= 0; k--) begin
      if ((NODE_COUNT << k) <= 511) begin
        if (r >= RW'(NODE_COUNT << k)) begin
          r = r - RW'(NODE_COUNT << k);
        end
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [7:0] ent_sym(input logic [EW-1:0] e);
    return e[EW-1 -: 8];
  endfunction

  function automatic logic [AW-1:0] ent_child(input logic [EW-1:0] e, input logic b);
    return b ? e[AW-1:0] : e[2*AW-1:AW];
  endfunction

  // node table
  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  // walk state
  logic [2:0]    state_r, state_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic          mid_r, mid_nxt;
  logic [AW-1:0] cur_idx_r, cur_idx_nxt;
  logic [EW-1:0] cur_ent_r, cur_ent_nxt;
  logic [EW-1:0] root_ent_r, root_ent_nxt;
  logic [AW-1:0] child_idx_r, child_idx_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  // registers
  logic [8:0]    root_r;
  logic [AW-1:0] root_w_r;
  logic [31:0]   total_r;

  logic          in_acc;
  logic          cfg_wr;
  logic [EW-1:0] node_ent;
  logic [EW-1:0] walk_ent;
  logic          child_leaf;
  logic          bit_now, bit_next;
  logic [31:0]   cnt_inc;
  logic          done_now;
  logic          last_bit;

  stage_ctl_t    stage_ctl;
  stage_sts_t    stage_sts;
  result_t       res;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign node_ent   = mid_r ? cur_ent_r : root_ent_r;
  assign child_leaf = (ent_sym(rd_data_r) != INTERNAL_MARK);
  // entry of the node the next bit starts from, after a child step
  assign walk_ent   = child_leaf ? root_ent_r : rd_data_r;
  assign bit_now    = byte_r[bit_r];
  assign bit_next   = byte_r[bit_r - 3'd1];
  assign cnt_inc    = cnt_r + 32'd1;
  assign done_now   = (total_r != 32'd0) && (cnt_inc >= total_r);
  assign last_bit   = done_now || (bit_r == 3'd0);

  // children are stored already reduced, so table reads need no wrap
  assign wr_addr = wrap_idx(in_node_index);
  assign wr_data = {in_node_symbol, wrap_idx(in_left_child), wrap_idx(in_right_child)};

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    mid_nxt       = mid_r;
    cur_idx_nxt   = cur_idx_r;
    cur_ent_nxt   = cur_ent_r;
    root_ent_nxt  = root_ent_r;
    child_idx_nxt = child_idx_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    stage_ctl     = '0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_WRITE) begin
            wr_en = 1'b1;
          end else if (!done_r) begin
            // bytes after the end of stream are dropped
            byte_nxt  = in_compressed_byte;
            bit_nxt   = 3'd7;
            rd_en     = 1'b1;
            rd_addr   = root_w_r;
            state_nxt = S_LROOT;
          end
        end
      end

      S_LROOT: begin
        root_ent_nxt = rd_data_r;
        rd_en        = 1'b1;
        rd_addr      = cur_idx_r;
        state_nxt    = S_LCUR;
      end

      S_LCUR: begin
        cur_ent_nxt = rd_data_r;
        state_nxt   = S_BIT;
      end

      S_BIT: begin
        if (ent_sym(node_ent) != INTERNAL_MARK) begin
          // walk sits on a leaf: the bit emits it directly
          res.symbol    = ent_sym(node_ent);
          res.sym_valid = 1'b1;
          res.eos       = done_now;
          if (stage_sts.can_push) begin
            stage_ctl.push = 1'b1;
            mid_nxt        = 1'b0;
            cnt_nxt        = cnt_inc;
            done_nxt       = done_now;
            if (last_bit) begin
              state_nxt = S_FLUSH;
            end else begin
              bit_nxt = bit_r - 3'd1;
            end
          end
        end else begin
          rd_en         = 1'b1;
          rd_addr       = ent_child(node_ent, bit_now);
          child_idx_nxt = rd_addr;
          state_nxt     = S_CHILD;
        end
      end

      S_CHILD: begin
        res.symbol    = child_leaf ? ent_sym(rd_data_r) : 8'd0;
        res.sym_valid = child_leaf;
        res.eos       = done_now;
        // hold the whole step while a result cannot be taken
        if (!((child_leaf || done_now) && !stage_sts.can_push)) begin
          stage_ctl.push = child_leaf || done_now;
          cnt_nxt        = cnt_inc;
          done_nxt       = done_now;
          if (child_leaf) begin
            mid_nxt = 1'b0;
          end else begin
            mid_nxt     = 1'b1;
            cur_idx_nxt = child_idx_r;
            cur_ent_nxt = rd_data_r;
          end
          if (last_bit) begin
            state_nxt = S_FLUSH;
          end else begin
            bit_nxt = bit_r - 3'd1;
            // start the next bit in the same cycle when it leaves an internal node
            if (ent_sym(walk_ent) == INTERNAL_MARK) begin
              rd_en         = 1'b1;
              rd_addr       = ent_child(walk_ent, bit_next);
              child_idx_nxt = rd_addr;
            end else begin
              state_nxt = S_BIT;
            end
          end
        end
      end

      S_FLUSH: begin
        stage_ctl.flush = 1'b1;
        if (stage_sts.can_flush) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // node table, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mid_r     <= 1'b0;
      cur_idx_r <= '0;
      cnt_r     <= 32'd0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mid_r     <= mid_nxt;
      cur_idx_r <= cur_idx_nxt;
      cnt_r     <= cnt_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    bit_r       <= bit_nxt;
    cur_ent_r   <= cur_ent_nxt;
    root_ent_r  <= root_ent_nxt;
    child_idx_r <= child_idx_nxt;
  end

  // configuration registers, paddr bit 2 selects the register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL) ? total_r : {23'd0, root_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r   <= 9'd0;
      root_w_r <= '0;
      total_r  <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROOT) begin
        root_r   <= pwdata[8:0];
        root_w_r <= wrap_idx(pwdata[8:0]);
      end else begin
        total_r <= pwdata;
      end
    end
  end

  hbd_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (stage_ctl),
    .res               (res),
    .sts               (stage_sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_symbol_valid  (out_symbol_valid),
    .out_end_of_stream (out_end_of_stream),
    .out_last_of_byte  (out_last_of_byte)
  );

  // a result is only handed over when the stage can take it
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stage_ctl.push |-> stage_sts.can_push)
    else $error("result pushed without room in output stage");

  // a byte step never pushes and closes at once
  a_push_flush: assert property (@(posedge clk) disable iff (!rst_n)
    !(stage_ctl.push && stage_ctl.flush))
    else $error("push and flush in the same cycle");

  // after the end of stream no byte starts a walk
  a_no_walk_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && state_r == S_IDLE) |=> (state_r != S_LROOT))
    else $error("walk started after end of stream");

  // the bit count moves by one per consumed bit
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("bit count jumped");

endmodule
